// ----- sv/pps_pkg.sv -----
// Shared constants and control types for the priority periodic task selector.
`timescale 1ns / 1ps

package pps_pkg;

    // Default table depth
    localparam int MAX_TASKS_DEF = 8;

    // Period is one second in microseconds over the rate
    localparam int QUO_W = 20;
    localparam logic [QUO_W-1:0] US_PER_SECOND = 20'd1000000;

    // Item field widths
    localparam int NOW_W  = 32;
    localparam int RATE_W = 16;
    localparam int PRIO_W = 8;
    localparam int ID_W   = 3;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_IDLE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic rotate;
        logic div_step;
        logic insert;
        logic emit;
    } pps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic reject;
    } pps_stat_t;

endpackage

// ----- sv/pps_ctrl.sv -----
// Controller state machine of the priority periodic task selector.
`timescale 1ns / 1ps

module pps_ctrl #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
    parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              command,
    output logic              in_stall,
    input  logic              out_stall,
    output logic              out_valid,
    input  pps_pkg::pps_stat_t stat,
    output pps_pkg::pps_cmd_t  cmd,
    output logic [IDX_W-1:0]  scan_idx
);

    localparam int ADD_STEPS = (MAX_TASKS > pps_pkg::QUO_W) ? MAX_TASKS : pps_pkg::QUO_W;
    localparam int STEP_W    = $clog2(ADD_STEPS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WORK   = 2'd1;
    localparam logic [1:0] S_INSERT = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              is_add_reg, is_add_next;
    logic              out_valid_reg, out_valid_next;
    logic [STEP_W-1:0] last_step;
    logic              busy_work;

    assign last_step = is_add_reg ? STEP_W'(ADD_STEPS - 1) : STEP_W'(MAX_TASKS - 1);
    assign busy_work = (state_reg == S_WORK) && !(is_add_reg && stat.reject);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        is_add_next    = is_add_reg;
        cmd            = '0;
        cmd.rotate     = busy_work && (step_reg < STEP_W'(MAX_TASKS));
        cmd.div_step   = busy_work && is_add_reg && (step_reg < STEP_W'(pps_pkg::QUO_W));
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    step_next   = '0;
                    is_add_next = (command == pps_pkg::CMD_ADD);
                    state_next  = S_WORK;
                end
            end
            S_WORK:
            begin
                if (is_add_reg && stat.reject)
                    state_next = S_EMIT;
                else if (step_reg == last_step)
                    state_next = is_add_reg ? S_INSERT : S_EMIT;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        out_valid_next = cmd.emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            is_add_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            is_add_reg    <= is_add_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign scan_idx  = step_reg[IDX_W-1:0];

endmodule

// ----- sv/pps_dp.sv -----
// Datapath of the priority periodic task selector: task ring, divider, result.
`timescale 1ns / 1ps

module pps_dp #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
    parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pps_pkg::pps_cmd_t           cmd,
    input  logic [IDX_W-1:0]            scan_idx,
    output pps_pkg::pps_stat_t          stat,
    input  logic                        command,
    input  logic [pps_pkg::NOW_W-1:0]   now_us,
    input  logic [pps_pkg::RATE_W-1:0]  rate_hz,
    input  logic [pps_pkg::PRIO_W-1:0]  task_priority,
    output logic [pps_pkg::STAT_W-1:0]  status,
    output logic [pps_pkg::ID_W-1:0]    task_id
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int QW    = pps_pkg::QUO_W;
    localparam int RW    = pps_pkg::RATE_W;

    // Task ring, entry 0 is the head seen by the scan
    logic [QW-1:0]                period_mem [MAX_TASKS];
    logic [pps_pkg::NOW_W-1:0]    last_mem   [MAX_TASKS];
    logic [pps_pkg::PRIO_W-1:0]   prio_mem   [MAX_TASKS];
    logic [pps_pkg::ID_W-1:0]     id_mem     [MAX_TASKS];
    logic                         run_mem    [MAX_TASKS];

    logic [CNT_W-1:0]             count_reg;
    logic                         cmd_reg;
    logic [pps_pkg::NOW_W-1:0]    now_reg;
    logic [RW-1:0]                rate_reg;
    logic [pps_pkg::PRIO_W-1:0]   prio_reg;
    logic                         zero_reg;
    logic                         full_reg;
    logic [pps_pkg::ID_W-1:0]     new_id_reg;
    logic                         found_reg;
    logic [pps_pkg::ID_W-1:0]     found_id_reg;
    logic [CNT_W-1:0]             pos_reg;
    logic [RW:0]                  rem_reg;
    logic [QW-1:0]                dvd_reg;
    logic [QW-1:0]                quo_reg;
    logic [pps_pkg::STAT_W-1:0]   status_reg;
    logic [pps_pkg::ID_W-1:0]     task_id_reg;

    logic [pps_pkg::NOW_W-1:0]    elapsed;
    logic                         in_range;
    logic                         due;
    logic                         hit;
    logic [RW:0]                  rem_sh;
    logic                         rem_ge;
    logic [CNT_W+pps_pkg::ID_W-1:0] count_ext;
    logic [pps_pkg::STAT_W-1:0]   res_status;
    logic [pps_pkg::ID_W-1:0]     res_id;

    assign stat.reject = zero_reg || full_reg;

    // Head entry check
    assign elapsed  = now_reg - last_mem[0];
    assign in_range = (CNT_W'(scan_idx) < count_reg);
    assign due      = ({{(pps_pkg::NOW_W-QW){1'b0}}, period_mem[0]} <= elapsed) || !run_mem[0];
    assign hit      = cmd.rotate && (cmd_reg == pps_pkg::CMD_SELECT) && in_range
                      && !found_reg && due;

    // Restoring divider, one quotient bit a step
    assign rem_sh = {rem_reg[RW-1:0], dvd_reg[QW-1]};
    assign rem_ge = (rem_sh >= {1'b0, rate_reg});

    // Id is the count at the time of the add, modulo eight
    assign count_ext = {{pps_pkg::ID_W{1'b0}}, count_reg};

    always_comb
    begin
        res_status = pps_pkg::ST_OK;
        res_id     = '0;
        if (cmd_reg == pps_pkg::CMD_SELECT)
        begin
            if (found_reg)
                res_id = found_id_reg;
            else
                res_status = pps_pkg::ST_IDLE;
        end
        else if (zero_reg)
            res_status = pps_pkg::ST_ZERO;
        else if (full_reg)
            res_status = pps_pkg::ST_FULL;
        else
            res_id = new_id_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.insert)
            count_reg <= count_reg + CNT_W'(1);
    end

    // Item capture, scan and divider
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= command;
            now_reg    <= now_us;
            rate_reg   <= rate_hz;
            prio_reg   <= task_priority;
            zero_reg   <= (command == pps_pkg::CMD_ADD) && (rate_hz == '0);
            full_reg   <= (command == pps_pkg::CMD_ADD) && (count_reg == CNT_W'(MAX_TASKS));
            new_id_reg <= count_ext[pps_pkg::ID_W-1:0];
            found_reg  <= 1'b0;
            pos_reg    <= '0;
            rem_reg    <= '0;
            dvd_reg    <= pps_pkg::US_PER_SECOND;
            quo_reg    <= '0;
        end
        else
        begin
            if (hit)
            begin
                found_reg    <= 1'b1;
                found_id_reg <= id_mem[0];
            end
            if (cmd.rotate && (cmd_reg == pps_pkg::CMD_ADD) && in_range
                && (prio_mem[0] > prio_reg))
                pos_reg <= pos_reg + CNT_W'(1);
            if (cmd.div_step)
            begin
                rem_reg <= rem_ge ? (rem_sh - {1'b0, rate_reg}) : rem_sh;
                quo_reg <= {quo_reg[QW-2:0], rem_ge};
                dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
            end
        end
    end

    // Ring: rotate by one entry a step, or open a slot and insert
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (cmd.rotate)
            begin
                period_mem[i] <= period_mem[(i + 1) % MAX_TASKS];
                prio_mem[i]   <= prio_mem[(i + 1) % MAX_TASKS];
                id_mem[i]     <= id_mem[(i + 1) % MAX_TASKS];
                last_mem[i]   <= (i == MAX_TASKS - 1 && hit) ? now_reg
                                 : last_mem[(i + 1) % MAX_TASKS];
                run_mem[i]    <= (i == MAX_TASKS - 1 && hit) ? 1'b1
                                 : run_mem[(i + 1) % MAX_TASKS];
            end
            else if (cmd.insert)
            begin
                if (CNT_W'(i) > pos_reg)
                begin
                    period_mem[i] <= period_mem[(i + MAX_TASKS - 1) % MAX_TASKS];
                    prio_mem[i]   <= prio_mem[(i + MAX_TASKS - 1) % MAX_TASKS];
                    id_mem[i]     <= id_mem[(i + MAX_TASKS - 1) % MAX_TASKS];
                    last_mem[i]   <= last_mem[(i + MAX_TASKS - 1) % MAX_TASKS];
                    run_mem[i]    <= run_mem[(i + MAX_TASKS - 1) % MAX_TASKS];
                end
                else if (CNT_W'(i) == pos_reg)
                begin
                    period_mem[i] <= quo_reg;
                    prio_mem[i]   <= prio_reg;
                    id_mem[i]     <= new_id_reg;
                    last_mem[i]   <= '0;
                    run_mem[i]    <= 1'b0;
                end
            end
        end
    end

    // Output register, loaded only when the previous result has gone
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg  <= res_status;
            task_id_reg <= res_id;
        end
    end

    assign status  = status_reg;
    assign task_id = task_id_reg;

endmodule

// ----- sv/priority_periodic_task_selector.sv -----
// Top level of the priority periodic task selector.
`timescale 1ns / 1ps

// Fixed-priority periodic task selector.
// Input channel (in_valid / in_stall) carries one command item: an add
// (command 0: rate_hz, task_priority) or a select (command 1: now_us).
// Output channel (out_valid / out_stall) returns exactly one result item
// per command: status and task_id (task_id is 0 unless status is ok).
// One item is worked on at a time; in_stall is high from acceptance until
// the result has been loaded into the output register.
// Select: the task ring is rotated past a single head compare, one entry
// a cycle. Add: the same rotation finds the insert slot while a restoring
// divider forms 1000000 / rate_hz one quotient bit a cycle; a rejected add
// goes straight to its result with no scan or insert.
// The next item is accepted the cycle after the result is loaded.
// Reset empties the table (task count zero) and drops any pending result.
// When the receiver stalls, the result holds in the output register; a new
// item may still be accepted and worked, but its result waits until the
// held one is taken.
module priority_periodic_task_selector #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [pps_pkg::NOW_W-1:0]   now_us,
    input  logic [pps_pkg::RATE_W-1:0]  rate_hz,
    input  logic [pps_pkg::PRIO_W-1:0]  task_priority,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pps_pkg::STAT_W-1:0]  status,
    output logic [pps_pkg::ID_W-1:0]    task_id
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    pps_pkg::pps_cmd_t  cmd;
    pps_pkg::pps_stat_t stat;
    logic [IDX_W-1:0]   scan_idx;

    // Sequencer: accept, step the scan and divider, insert, emit
    pps_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd),
        .scan_idx  (scan_idx)
    );

    // Task ring, divider and output register
    pps_dp #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .scan_idx      (scan_idx),
        .stat          (stat),
        .command       (command),
        .now_us        (now_us),
        .rate_hz       (rate_hz),
        .task_priority (task_priority),
        .status        (status),
        .task_id       (task_id)
    );

    // An accepted item keeps the input side busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again straight after an accept");

    // Load, insert and emit never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.insert, cmd.emit}))
        else $error("overlapping sequencer commands");

    // Ring rotation and insertion are exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rotate && cmd.insert))
        else $error("rotate and insert in one cycle");

    // No task id accompanies a non-ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != pps_pkg::ST_OK) |-> (task_id == '0))
        else $error("task id set on a non-ok result");

endmodule
